// ===== rtl/bitmap_page_frame_allocator_assert.svh =====
// Assertion macros used by the page frame allocator datapath (bpfa_dp).
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpfa assertion failed");

// next-cycle implication
`define BPFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpfa assertion failed");

`endif

// ===== rtl/bpfa_pkg.sv =====
// Shared types and constants of the bitmap page frame allocator.
// No dependencies.
package bpfa_pkg;

  localparam int PAGE_W   = 15;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_DECODE   = 11'b000_0000_0100,
    S_DIV1     = 11'b000_0000_1000,
    S_DIV2     = 11'b000_0001_0000,
    S_RMW_RD   = 11'b000_0010_0000,
    S_RMW_WR   = 11'b000_0100_0000,
    S_SCAN_RD  = 11'b000_1000_0000,
    S_SCAN_CK  = 11'b001_0000_0000,
    S_ALLOC_WR = 11'b010_0000_0000,
    S_RESULT   = 11'b100_0000_0000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic fast_load;
    logic range_err;
    logic oom;
    logic div1;
    logic div2;
    logic rmw_rd;
    logic rmw_wr;
    logic scan_start;
    logic scan_rd;
    logic scan_ck;
    logic scan_next;
    logic alloc_wr;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            out_of_range;
    logic            fast_pending;
    logic            map_empty;
    logic            word_nonzero;
    logic            scan_last;
    logic            out_free;
  } sts_t;

endpackage

// ===== rtl/bpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bpfa_ctrl.sv =====
// Sequencer of the page frame allocator: clearing pass, decode, divide,
// read-modify-write and word scan. Depends on bpfa_pkg.
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_ALLOC: begin
            if (sts.fast_pending) begin
              cmd.fast_load = 1'b1;
              state_nxt     = S_DIV1;
            end else if (sts.map_empty) begin
              cmd.oom   = 1'b1;
              state_nxt = S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN_RD;
            end
          end
          OP_FREE, OP_MARK: begin
            if (sts.out_of_range) begin
              cmd.range_err = 1'b1;
              state_nxt     = S_RESULT;
            end else begin
              state_nxt = S_DIV1;
            end
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_DIV1: begin
        cmd.div1  = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2  = 1'b1;
        state_nxt = S_RMW_RD;
      end
      S_RMW_RD: begin
        cmd.rmw_rd = 1'b1;
        state_nxt  = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.rmw_wr = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        cmd.scan_ck = 1'b1;
        if (sts.word_nonzero) begin
          state_nxt = S_ALLOC_WR;
        end else if (sts.scan_last) begin
          cmd.oom   = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== rtl/bpfa_dp.sv =====
// Datapath of the page frame allocator: request registers, page divider,
// bitmap RAM, scan pointer, fast-path cache and output register.
// Depends on bpfa_pkg, bpfa_ram and the assertion macro header.
`include "bitmap_page_frame_allocator_assert.svh"

module bpfa_dp import bpfa_pkg::*; #(
  parameter int WORD_COUNT    = 1024,
  parameter int BITS_PER_WORD = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic [1:0]          out_tuser
);

  localparam int WIDX_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int LOW_W     = $clog2(WORD_COUNT + 1);
  localparam int BIT_W     = $clog2(BITS_PER_WORD);
  localparam int DIV_SHIFT = 22;
  localparam int RECIP     = (1 << DIV_SHIFT) / BITS_PER_WORD;
  localparam int PROD_W    = PAGE_W + DIV_SHIFT;

  localparam logic [DIV_SHIFT-1:0] RECIP_V   = DIV_SHIFT'(RECIP);
  localparam logic [31:0]          CAPACITY  = 32'(WORD_COUNT) * 32'(BITS_PER_WORD);
  localparam logic [LOW_W-1:0]     LOW_EMPTY = LOW_W'(WORD_COUNT);
  localparam logic [PAGE_W-1:0]    BPW_P     = PAGE_W'(BITS_PER_WORD);

  logic [OP_W-1:0]          op_r;
  logic [PAGE_W-1:0]        page_r;
  logic [PAGE_W-1:0]        q0_r;
  logic [WIDX_W-1:0]        word_r;
  logic [BIT_W-1:0]         bit_r;
  logic [WIDX_W-1:0]        scan_r;
  logic [LOW_W-1:0]         low_r;
  logic [WIDX_W-1:0]        clr_r;
  logic [PAGE_W-1:0]        cached_r;
  logic                     fast_r;
  logic [PAGE_W-1:0]        res_grant_r;
  status_t                  res_status_r;
  logic                     out_valid_r;
  logic [PAGE_W-1:0]        out_grant_r;
  status_t                  out_status_r;

  logic [PROD_W-1:0]        div_prod;
  logic [PAGE_W-1:0]        back_prod;
  logic [PAGE_W-1:0]        rem_raw;
  logic                     rem_over;
  logic [BITS_PER_WORD-1:0] rd_data;
  logic [BITS_PER_WORD-1:0] bit_mask;
  logic [BITS_PER_WORD-1:0] low_bit;
  logic [BIT_W-1:0]         bit_enc;
  logic [31:0]              grant_calc;
  logic                     mem_we;
  logic [WIDX_W-1:0]        mem_waddr;
  logic [BITS_PER_WORD-1:0] mem_wdata;
  logic                     mem_re;
  logic [WIDX_W-1:0]        mem_raddr;

  // page / BITS_PER_WORD by reciprocal; estimate is low by at most one
  assign div_prod   = {{DIV_SHIFT{1'b0}}, page_r} * {{PAGE_W{1'b0}}, RECIP_V};
  assign back_prod  = PAGE_W'(32'(q0_r) * 32'(BITS_PER_WORD));
  assign rem_raw    = page_r - back_prod;
  assign rem_over   = (rem_raw >= BPW_P);

  assign bit_mask   = {{(BITS_PER_WORD-1){1'b0}}, 1'b1} << bit_r;

  // isolate lowest set bit, then encode its position
  assign low_bit    = rd_data & (~rd_data + {{(BITS_PER_WORD-1){1'b0}}, 1'b1});
  always_comb begin
    bit_enc = '0;
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      if (low_bit[i]) bit_enc = bit_enc | BIT_W'(i);
    end
  end

  assign grant_calc = 32'(scan_r) * 32'(BITS_PER_WORD) + 32'(bit_r);

  always_comb begin
    mem_we    = cmd.clr_step | cmd.rmw_wr | cmd.alloc_wr;
    mem_waddr = scan_r;
    mem_wdata = rd_data & ~bit_mask;
    if (cmd.clr_step) begin
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (cmd.rmw_wr) begin
      mem_waddr = word_r;
      if (op_r == OP_FREE) mem_wdata = rd_data | bit_mask;
    end
    mem_re    = cmd.rmw_rd | cmd.scan_rd;
    mem_raddr = cmd.rmw_rd ? word_r : scan_r;
  end

  bpfa_ram #(
    .WIDTH (BITS_PER_WORD),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r         <= in_tuser;
      page_r       <= in_tdata[PAGE_W-1:0];
      res_grant_r  <= '0;
      res_status_r <= ST_OK;
    end
    if (cmd.fast_load) begin
      page_r      <= cached_r;
      res_grant_r <= cached_r;
    end
    if (cmd.range_err) res_status_r <= ST_RANGE;
    if (cmd.oom)       res_status_r <= ST_OOM;
    if (cmd.div1)      q0_r <= div_prod[DIV_SHIFT +: PAGE_W];
    if (cmd.div2) begin
      if (rem_over) begin
        word_r <= WIDX_W'(q0_r + 1'b1);
        bit_r  <= BIT_W'(rem_raw - BPW_P);
      end else begin
        word_r <= WIDX_W'(q0_r);
        bit_r  <= BIT_W'(rem_raw);
      end
    end
    if (cmd.scan_start) scan_r <= low_r[WIDX_W-1:0];
    if (cmd.scan_next)  scan_r <= scan_r + 1'b1;
    if (cmd.scan_ck)    bit_r  <= bit_enc;
    if (cmd.alloc_wr)   res_grant_r <= grant_calc[PAGE_W-1:0];
    if (cmd.load_out) begin
      out_grant_r  <= res_grant_r;
      out_status_r <= res_status_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      low_r       <= LOW_EMPTY;
      cached_r    <= '0;
      fast_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.fast_load) fast_r <= 1'b0;
      if (cmd.rmw_wr) begin
        if (op_r == OP_FREE) begin
          cached_r <= page_r;
          fast_r   <= 1'b1;
          if (LOW_W'(word_r) < low_r) low_r <= LOW_W'(word_r);
        end else if (op_r == OP_MARK && cached_r == page_r) begin
          // marking the cached page used cancels the fast path
          fast_r <= 1'b0;
        end
      end
      // words below the hit are all zero
      if (cmd.alloc_wr) low_r <= LOW_W'(scan_r);
      if (cmd.oom)      low_r <= LOW_EMPTY;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last     = (clr_r == WIDX_W'(WORD_COUNT - 1));
  assign sts.op           = op_r;
  assign sts.out_of_range = ({{(32-PAGE_W){1'b0}}, page_r} >= CAPACITY);
  assign sts.fast_pending = fast_r;
  assign sts.map_empty    = (low_r == LOW_EMPTY);
  assign sts.word_nonzero = |rd_data;
  assign sts.scan_last    = (scan_r == WIDX_W'(WORD_COUNT - 1));
  assign sts.out_free     = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_grant_r};
  assign out_tuser  = out_status_r;

  `BPFA_ASSERT_IMP(a_alloc_clears_one, cmd.alloc_wr, ($countones(mem_wdata) + 1 == $countones(rd_data)))
  `BPFA_ASSERT_IMP(a_scan_not_empty, cmd.scan_start, low_r != LOW_EMPTY)
  `BPFA_ASSERT_IMP(a_fail_no_grant, cmd.load_out && res_status_r != ST_OK, res_grant_r == '0)
  `BPFA_ASSERT_NXT(a_free_caches, cmd.rmw_wr && op_r == OP_FREE, fast_r && cached_r == $past(page_r))

endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap page frame allocator.
// Depends on bpfa_pkg, bpfa_ctrl, bpfa_dp (and bpfa_ram below it).
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tdata: page_index, tuser: operation
// out_     out  out_tvalid/out_tready tdata: granted_page, tuser: status
//
// After reset a clearing pass writes zero to all WORD_COUNT bitmap words, one
// per cycle, with in_tready low. Free, mark-used and fast-path allocate go
// from accept to result through decode, the divider states DIV1 and DIV2,
// then a read and a write of the bitmap RAM. A scanning allocate reads the
// words from the low-water mark up to the first nonzero word, one RAM read and
// one check each, then clears the granted bit; a scan that runs past the
// last word reports out of memory. Out-of-range requests, unused codes and
// allocates on an empty map go from decode straight to the result.
// One result waits in the output register; the next item is accepted meanwhile
// and finishes once that register is taken.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int WORD_COUNT    = 1024,
  parameter int BITS_PER_WORD = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] page_index, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] granted_page, [15] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  cmd_t cmd;
  sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpfa_dp #(
    .WORD_COUNT    (WORD_COUNT),
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
